[sv/lfy_pkg.sv]
// lfy_pkg: constants, microcode word type and control store for the shuffle block
// used by lcg_fisher_yates_shuffle; no dependencies
`default_nettype none

package lfy_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int LEN_W       = $clog2(MAX_ENTRIES + 1);
  localparam int SEED_W      = 32;
  localparam int UPC_W       = 4;
  localparam int DIV_STEPS   = SEED_W / 2;
  localparam int DCNT_W      = $clog2(DIV_STEPS);

  localparam logic [LEN_W-1:0]  LEN_RESET = LEN_W'(60);
  localparam logic [SEED_W-1:0] LCG_MUL   = 32'd1337420;
  localparam logic [SEED_W-1:0] LCG_ADD   = 32'd40469;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [UPC_W-1:0] upc_t;
  typedef logic [3:0]       op_t;
  typedef logic [2:0]       cond_t;

  // datapath operations
  localparam op_t OP_NOP   = 4'd0;
  localparam op_t OP_LOAD  = 4'd1;   // take request: seed, length, counters
  localparam op_t OP_MUL   = 4'd2;
  localparam op_t OP_ADD   = 4'd3;   // finish lcg step, arm the divider
  localparam op_t OP_DIV   = 4'd4;   // two dividend bits per step
  localparam op_t OP_DEC   = 4'd5;
  localparam op_t OP_RDI   = 4'd6;
  localparam op_t OP_RDJ   = 4'd7;
  localparam op_t OP_WRI   = 4'd8;
  localparam op_t OP_WRJ   = 4'd9;
  localparam op_t OP_EMRD  = 4'd10;
  localparam op_t OP_EMOUT = 4'd11;

  // jump conditions
  localparam cond_t CD_NEXT    = 3'd0;
  localparam cond_t CD_JMP     = 3'd1;
  localparam cond_t CD_NOSTART = 3'd2;
  localparam cond_t CD_ILT2    = 3'd3;
  localparam cond_t CD_DIVMORE = 3'd4;
  localparam cond_t CD_KEQLEN  = 3'd5;

  // program labels
  localparam upc_t ST_WAIT  = 4'd0;
  localparam upc_t ST_CHKI  = 4'd1;
  localparam upc_t ST_MUL   = 4'd2;
  localparam upc_t ST_ADD   = 4'd3;
  localparam upc_t ST_DIV   = 4'd4;
  localparam upc_t ST_DEC   = 4'd5;
  localparam upc_t ST_RDI   = 4'd6;
  localparam upc_t ST_RDJ   = 4'd7;
  localparam upc_t ST_WRI   = 4'd8;
  localparam upc_t ST_WRJ   = 4'd9;
  localparam upc_t ST_EMCHK = 4'd10;
  localparam upc_t ST_EMRD  = 4'd11;
  localparam upc_t ST_EMOUT = 4'd12;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } ucw_t;

  function automatic ucw_t ucode(input upc_t upc);
    ucw_t w;
    unique case (upc)
      ST_WAIT:  w = '{op: OP_LOAD,  cond: CD_NOSTART, target: ST_WAIT};
      ST_CHKI:  w = '{op: OP_NOP,   cond: CD_ILT2,    target: ST_EMCHK};
      ST_MUL:   w = '{op: OP_MUL,   cond: CD_NEXT,    target: ST_WAIT};
      ST_ADD:   w = '{op: OP_ADD,   cond: CD_NEXT,    target: ST_WAIT};
      ST_DIV:   w = '{op: OP_DIV,   cond: CD_DIVMORE, target: ST_DIV};
      ST_DEC:   w = '{op: OP_DEC,   cond: CD_NEXT,    target: ST_WAIT};
      ST_RDI:   w = '{op: OP_RDI,   cond: CD_NEXT,    target: ST_WAIT};
      ST_RDJ:   w = '{op: OP_RDJ,   cond: CD_NEXT,    target: ST_WAIT};
      ST_WRI:   w = '{op: OP_WRI,   cond: CD_NEXT,    target: ST_WAIT};
      ST_WRJ:   w = '{op: OP_WRJ,   cond: CD_JMP,     target: ST_CHKI};
      ST_EMCHK: w = '{op: OP_NOP,   cond: CD_KEQLEN,  target: ST_WAIT};
      ST_EMRD:  w = '{op: OP_EMRD,  cond: CD_NEXT,    target: ST_WAIT};
      ST_EMOUT: w = '{op: OP_EMOUT, cond: CD_JMP,     target: ST_EMCHK};
      default:  w = '{op: OP_NOP,   cond: CD_JMP,     target: ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[sv/lfy_ram.sv]
// lfy_ram: generic simple dual-port ram, one write and one registered read port
// standalone, no package dependencies
`default_nettype none

module lfy_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

[sv/lcg_fisher_yates_shuffle.sv]
// lcg_fisher_yates_shuffle: microcoded lcg-driven in-place shuffle of an order table
// depends on lfy_pkg (constants, control store) and lfy_ram (order table storage)
//
//  channel   ports                                                handshake
//  request   in_seed_value                                        start / busy
//  result    out_position, out_entry_index, out_last_item         out_strobe, one cycle
//  config    cfg_list_length                                      cfg_valid / cfg_ready
//
// a request runs length-1 swaps (check, multiply, add, 16 divider steps, decrement, four
// ram accesses), then reads and emits each entry in turn; its pace is set by the single
// ram read port and the 2-bit-per-cycle remainder unit. synchronous reset restores length
// 60 and an identity table through per-entry valid bits, no clearing pass. results cannot
// be stalled; busy stays high until the last result is registered. config writes are
// always taken.
`default_nettype none

module lcg_fisher_yates_shuffle (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [31:0]              in_seed_value,
  output logic                          out_strobe,
  output logic [5:0]                    out_position,
  output logic [5:0]                    out_entry_index,
  output logic                          out_last_item,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [6:0]               cfg_list_length
);

  lfy_pkg::upc_t  upc_r, upc_nxt;
  lfy_pkg::ucw_t  uw;
  lfy_pkg::len_t  cfg_len_r, len_r, i_r, k_r;
  lfy_pkg::len_t  len_sat;
  lfy_pkg::idx_t  j_r, tmp_r, rd_addr_r, ram_raddr, ram_waddr, ram_wdata, ram_q, rd_val;
  logic [lfy_pkg::SEED_W-1:0] seed_r, prod_r, seed_add;
  logic [lfy_pkg::DCNT_W-1:0] dcnt_r;
  logic [lfy_pkg::MAX_ENTRIES-1:0] valid_r;
  logic  ram_we, accept, take;
  logic [lfy_pkg::LEN_W-1:0] r1, r2;
  lfy_pkg::idx_t  r1m;

  assign uw        = lfy_pkg::ucode(upc_r);
  assign busy      = (upc_r != lfy_pkg::ST_WAIT);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // saturate to table size
  assign len_sat = (cfg_len_r > lfy_pkg::len_t'(lfy_pkg::MAX_ENTRIES))
                   ? lfy_pkg::len_t'(lfy_pkg::MAX_ENTRIES) : cfg_len_r;

  assign seed_add = prod_r + lfy_pkg::LCG_ADD;

  // entry never written reads as its own index
  assign rd_val = valid_r[rd_addr_r] ? ram_q : rd_addr_r;

  // two restoring-division steps, remainder stays below i
  always_comb begin
    r1  = {j_r, seed_r[lfy_pkg::SEED_W-1]};
    if (r1 >= i_r) begin
      r1 = r1 - i_r;
    end
    r1m = r1[lfy_pkg::IDX_W-1:0];
    r2  = {r1m, seed_r[lfy_pkg::SEED_W-2]};
    if (r2 >= i_r) begin
      r2 = r2 - i_r;
    end
  end

  always_comb begin
    unique case (uw.cond)
      lfy_pkg::CD_NEXT:    take = 1'b0;
      lfy_pkg::CD_JMP:     take = 1'b1;
      lfy_pkg::CD_NOSTART: take = !start;
      lfy_pkg::CD_ILT2:    take = (i_r < lfy_pkg::len_t'(2));
      lfy_pkg::CD_DIVMORE: take = (dcnt_r != lfy_pkg::DCNT_W'(lfy_pkg::DIV_STEPS - 1));
      lfy_pkg::CD_KEQLEN:  take = (k_r == len_r);
      default:             take = 1'b1;
    endcase
    upc_nxt = take ? uw.target : upc_r + lfy_pkg::upc_t'(1);
  end

  always_comb begin
    ram_raddr = rd_addr_r;
    ram_we    = 1'b0;
    ram_waddr = i_r[lfy_pkg::IDX_W-1:0];
    ram_wdata = rd_val;
    unique case (uw.op)
      lfy_pkg::OP_RDI:  ram_raddr = i_r[lfy_pkg::IDX_W-1:0];
      lfy_pkg::OP_RDJ:  ram_raddr = j_r;
      lfy_pkg::OP_EMRD: ram_raddr = k_r[lfy_pkg::IDX_W-1:0];
      lfy_pkg::OP_WRI:  ram_we = 1'b1;
      lfy_pkg::OP_WRJ: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = tmp_r;
      end
      default: ;
    endcase
  end

  lfy_ram #(
    .WIDTH(lfy_pkg::IDX_W),
    .DEPTH(lfy_pkg::MAX_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r      <= lfy_pkg::ST_WAIT;
      cfg_len_r  <= lfy_pkg::LEN_RESET;
      valid_r    <= '0;
      out_strobe <= 1'b0;
    end else begin
      upc_r      <= upc_nxt;
      out_strobe <= (uw.op == lfy_pkg::OP_EMOUT);
      if (cfg_valid && cfg_ready) begin
        cfg_len_r <= cfg_list_length;
      end
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rd_addr_r <= ram_raddr;
    unique case (uw.op)
      lfy_pkg::OP_LOAD: begin
        if (accept) begin
          seed_r <= in_seed_value;
          len_r  <= len_sat;
          i_r    <= len_sat;
          k_r    <= '0;
        end
      end
      lfy_pkg::OP_MUL: prod_r <= seed_r * lfy_pkg::LCG_MUL;
      lfy_pkg::OP_ADD: begin
        seed_r <= seed_add;
        j_r    <= '0;
        dcnt_r <= '0;
      end
      lfy_pkg::OP_DIV: begin
        // dividend rotates so the lcg state is intact after all steps
        seed_r <= {seed_r[lfy_pkg::SEED_W-3:0], seed_r[lfy_pkg::SEED_W-1 -: 2]};
        j_r    <= r2[lfy_pkg::IDX_W-1:0];
        dcnt_r <= dcnt_r + lfy_pkg::DCNT_W'(1);
      end
      lfy_pkg::OP_DEC: i_r <= i_r - lfy_pkg::len_t'(1);
      lfy_pkg::OP_RDJ: tmp_r <= rd_val;
      lfy_pkg::OP_EMOUT: begin
        out_position    <= k_r[lfy_pkg::IDX_W-1:0];
        out_entry_index <= rd_val;
        out_last_item   <= (k_r + lfy_pkg::len_t'(1) == len_r);
        k_r             <= k_r + lfy_pkg::len_t'(1);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
